>>> sv/ctgs_pkg.sv
// Shared types, constants and the character-to-glyph lookup of the text glyph streamer.
package ctgs_pkg;

  // Display geometry and field widths.
  localparam int DisplayColumnsDefault = 128;
  localparam int CellWidth             = 6;
  localparam int LineLenW              = 6;
  localparam int LineLenMax            = 63;
  localparam int PageW                 = 3;
  localparam int ByteW                 = 8;
  localparam int ColW                  = 8;

  // Font ROM geometry.
  localparam int GlyphCount = 62;
  localparam int GlyphCols  = 5;
  localparam int GlyphIdxW  = 6;
  localparam int GlyphColW  = 3;

  // Controller command bases and the blank spacing column.
  localparam logic [ByteW-1:0] PageCmdBase  = 8'hB0;
  localparam logic [ByteW-1:0] ColLoCmdBase = 8'h00;
  localparam logic [ByteW-1:0] ColHiCmdBase = 8'h10;
  localparam logic [ByteW-1:0] BlankColumn  = 8'h00;

  // Character ranges that have a glyph, and where each range starts in the ROM.
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [GlyphIdxW-1:0] LowerBase = 6'd26;
  localparam logic [GlyphIdxW-1:0] DigitBase = 6'd52;

  // Input and result items of the stream channels.
  typedef struct packed {
    logic [7:0]          character;
    logic                start_of_line;
    logic [PageW-1:0]    page_row;
    logic [LineLenW-1:0] line_length;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_command;
    logic             last_of_run;
  } out_item_t;

  // Glyph reference: ROM row and whether the character has a glyph at all.
  typedef struct packed {
    logic                 ok;
    logic [GlyphIdxW-1:0] idx;
  } glyph_ref_t;

  // One byte issued by the sequencer toward the output stage.
  typedef struct packed {
    logic                 valid;
    logic                 is_command;
    logic                 last_of_run;
    logic                 from_rom;
    logic [ByteW-1:0]     cmd_byte;
    logic                 glyph_ok;
    logic [GlyphIdxW-1:0] glyph_idx;
    logic [GlyphColW-1:0] glyph_col;
  } issue_t;

  // Map an ASCII code to its font row; codes without a glyph draw as a space.
  function automatic glyph_ref_t glyph_lookup(logic [7:0] ch);
    glyph_ref_t r;
    r.ok  = 1'b1;
    r.idx = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      r.idx = GlyphIdxW'(ch - CharUpperA);
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      r.idx = GlyphIdxW'(ch - CharLowerA) + LowerBase;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      r.idx = GlyphIdxW'(ch - CharDigit0) + DigitBase;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/ctgs_stream_if.sv
// Valid/ready stream channel carrying one payload item per transaction.
interface ctgs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/centered_text_glyph_streamer.sv
// Top level of the centered text glyph streamer: sequencer, font ROM and output register.
// A character's first byte passes the sequencer state register, then the output register.
// Throughput: one byte per cycle while output is ready and input keeps up, so 9 bytes per
// character at a line start, 6 otherwise; the single-byte output channel sets this rate.
// The next character is taken in the cycle its blank column moves to the output register.
// Reset clears the sequencer and the output valid; the font ROM needs no initialization.
module centered_text_glyph_streamer #(
  parameter int DISPLAY_COLUMNS = ctgs_pkg::DisplayColumnsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ctgs_stream_if.sink   in_i,
  ctgs_stream_if.source out_o
);

  ctgs_pkg::issue_t           issue_w;
  logic                       out_adv_w, issue_adv_w;
  logic                       out_valid_q;
  logic                       out_cmd_q, out_last_q, out_rom_q;
  logic [ctgs_pkg::ByteW-1:0] out_byte_q, rom_data_w;

  // The output register takes a byte when it is empty or being taken.
  assign out_adv_w   = !out_valid_q || out_o.ready;
  assign issue_adv_w = issue_w.valid && out_adv_w;

  ctgs_sequencer #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (issue_adv_w),
    .issue_o (issue_w)
  );

  // Glyph columns are read in the same cycle the byte enters the output register.
  ctgs_font_rom u_font_rom (
    .clk_i       (clk_i),
    .rd_en_i     (issue_adv_w && issue_w.from_rom),
    .glyph_ok_i  (issue_w.glyph_ok),
    .glyph_idx_i (issue_w.glyph_idx),
    .glyph_col_i (issue_w.glyph_col),
    .rd_data_o   (rom_data_w)
  );

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv_w) begin
      out_valid_q <= issue_w.valid;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    if (issue_adv_w) begin
      out_cmd_q  <= issue_w.is_command;
      out_last_q <= issue_w.last_of_run;
      out_rom_q  <= issue_w.from_rom;
      out_byte_q <= issue_w.cmd_byte;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.payload.out_byte    = out_rom_q ? rom_data_w : out_byte_q;
  assign out_o.payload.is_command  = out_cmd_q;
  assign out_o.payload.last_of_run = out_last_q;

endmodule

>>> sv/ctgs_font_rom.sv
// Synchronous 5x8 font ROM with one registered read port.
module ctgs_font_rom (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic                            glyph_ok_i,
  input  logic [ctgs_pkg::GlyphIdxW-1:0]  glyph_idx_i,
  input  logic [ctgs_pkg::GlyphColW-1:0]  glyph_col_i,
  output logic [ctgs_pkg::ByteW-1:0]      rd_data_o
);

  localparam int RowW = ctgs_pkg::GlyphCols * ctgs_pkg::ByteW;

  // Each row holds the five columns left to right, leftmost in the top byte.
  localparam logic [RowW-1:0] GlyphRom [ctgs_pkg::GlyphCount] = '{
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0304780403, 40'h6151494543, 40'h2054545478, 40'h7F48444438,
    40'h3844444420, 40'h384444487F, 40'h3854545418, 40'h087E090102,
    40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478,
    40'h3844444438, 40'h7C14141408, 40'h081414187C, 40'h7C08040408,
    40'h4854545420, 40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C, 40'h4464544C44,
    40'h3E4549513E, 40'h00417F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E
  };

  logic [ctgs_pkg::GlyphColW-1:0] lane;
  logic [ctgs_pkg::ByteW-1:0]     rd_data_q;

  // Column 0 sits in the top byte of a row.
  assign lane = ctgs_pkg::GlyphColW'(ctgs_pkg::GlyphCols - 1) - glyph_col_i;

  // Registered read; characters without a glyph read as an empty column.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (glyph_ok_i && (32'(glyph_idx_i) < ctgs_pkg::GlyphCount)) begin
        rd_data_q <= GlyphRom[glyph_idx_i][{lane, 3'b000} +: ctgs_pkg::ByteW];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/ctgs_sequencer.sv
// Per-character byte sequencer: line-start cursor commands, five glyph columns, a blank column.
module ctgs_sequencer #(
  parameter int DISPLAY_COLUMNS = ctgs_pkg::DisplayColumnsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ctgs_stream_if.sink      in_i,
  input  logic             adv_i,
  output ctgs_pkg::issue_t issue_o
);

  localparam int UsedW  = $clog2(ctgs_pkg::LineLenMax * ctgs_pkg::CellWidth + 1);
  localparam int DcW    = $clog2(DISPLAY_COLUMNS + 1);
  localparam int CalcW  = (UsedW > DcW) ? UsedW : DcW;
  localparam logic [ctgs_pkg::GlyphColW-1:0] LastCol =
    ctgs_pkg::GlyphColW'(ctgs_pkg::GlyphCols - 1);

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhPage  = 6'b000010,
    PhColLo = 6'b000100,
    PhColHi = 6'b001000,
    PhGlyph = 6'b010000,
    PhBlank = 6'b100000
  } seq_state_e;

  seq_state_e                     state_q, state_d, entry_w;
  logic [ctgs_pkg::GlyphColW-1:0] gcol_q, gcol_d;
  logic                           glyph_ok_q;
  logic [ctgs_pkg::GlyphIdxW-1:0] glyph_idx_q;
  logic [ctgs_pkg::PageW-1:0]     page_q;
  logic [ctgs_pkg::ColW-1:0]      col_q, col_w;
  logic [CalcW-1:0]               used_w, diff_w;
  ctgs_pkg::glyph_ref_t           gref_w;
  logic                           ready_w, accept_w;

  // A new character enters when idle or as the blank column of the current one leaves.
  assign ready_w  = (state_q == PhIdle) || ((state_q == PhBlank) && adv_i);
  assign in_i.ready = ready_w;
  assign accept_w = in_i.valid && ready_w;
  assign entry_w  = in_i.payload.start_of_line ? PhPage : PhGlyph;

  // Centering column: (width - 6 * length) / 2, zero when the line does not fit.
  always_comb begin
    used_w = (CalcW'(in_i.payload.line_length) << 2) + (CalcW'(in_i.payload.line_length) << 1);
    diff_w = CalcW'(DISPLAY_COLUMNS) - used_w;
    col_w  = '0;
    if (used_w < CalcW'(DISPLAY_COLUMNS)) begin
      col_w = ctgs_pkg::ColW'(diff_w >> 1);
    end
  end

  assign gref_w = ctgs_pkg::glyph_lookup(in_i.payload.character);

  // Next-state logic of the byte sequence.
  always_comb begin
    state_d = state_q;
    gcol_d  = gcol_q;
    unique case (state_q)
      PhIdle: begin
        if (accept_w) begin
          state_d = entry_w;
          gcol_d  = '0;
        end
      end
      PhPage: begin
        if (adv_i) state_d = PhColLo;
      end
      PhColLo: begin
        if (adv_i) state_d = PhColHi;
      end
      PhColHi: begin
        if (adv_i) begin
          state_d = PhGlyph;
          gcol_d  = '0;
        end
      end
      PhGlyph: begin
        if (adv_i) begin
          if (gcol_q == LastCol) begin
            state_d = PhBlank;
          end else begin
            gcol_d = gcol_q + 1'b1;
          end
        end
      end
      PhBlank: begin
        if (adv_i) begin
          if (accept_w) begin
            state_d = entry_w;
            gcol_d  = '0;
          end else begin
            state_d = PhIdle;
          end
        end
      end
      default: begin
        state_d = PhIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhIdle;
      gcol_q  <= '0;
    end else begin
      state_q <= state_d;
      gcol_q  <= gcol_d;
    end
  end

  // Character registers, loaded with each transaction.
  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      glyph_ok_q  <= gref_w.ok;
      glyph_idx_q <= gref_w.idx;
      page_q      <= in_i.payload.page_row;
      col_q       <= col_w;
    end
  end

  // Byte issued in the current step.
  always_comb begin
    issue_o             = '0;
    issue_o.valid       = (state_q != PhIdle);
    issue_o.glyph_ok    = glyph_ok_q;
    issue_o.glyph_idx   = glyph_idx_q;
    issue_o.glyph_col   = gcol_q;
    unique case (state_q)
      PhIdle: begin
        issue_o.valid = 1'b0;
      end
      PhPage: begin
        issue_o.is_command = 1'b1;
        issue_o.cmd_byte   = ctgs_pkg::PageCmdBase + ctgs_pkg::ByteW'(page_q);
      end
      PhColLo: begin
        issue_o.is_command = 1'b1;
        issue_o.cmd_byte   = ctgs_pkg::ColLoCmdBase + ctgs_pkg::ByteW'(col_q[3:0]);
      end
      PhColHi: begin
        issue_o.is_command = 1'b1;
        issue_o.cmd_byte   = ctgs_pkg::ColHiCmdBase + ctgs_pkg::ByteW'(col_q[7:4]);
      end
      PhGlyph: begin
        issue_o.from_rom = 1'b1;
      end
      PhBlank: begin
        issue_o.last_of_run = 1'b1;
        issue_o.cmd_byte    = ctgs_pkg::BlankColumn;
      end
      default: begin
        issue_o.valid = 1'b0;
      end
    endcase
  end

  // A character is taken only while no other one is still being sent.
  a_accept_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |-> (state_q == PhIdle) || ((state_q == PhBlank) && adv_i))
    else $error("character taken while a run is in progress");

  // The output stage advances only a byte that was actually issued.
  a_adv_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |-> (state_q != PhIdle))
    else $error("advance without an issued byte");

  // The glyph column counter never runs past the last column.
  a_gcol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PhGlyph) |-> (gcol_q <= LastCol))
    else $error("glyph column out of range");

  // After the high column command the glyph starts at its first column.
  a_cursor_to_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == PhColHi) && adv_i) |=> ((state_q == PhGlyph) && (gcol_q == '0)))
    else $error("glyph did not follow the cursor commands");

endmodule
